FILE: rtl/bgc_pkg.sv
// Package for the barrier gate controller: phase, event and register codes,
// register reset values and default widths. No dependencies.
package bgc_pkg;

	// Phase of the barrier sequence
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_OPENING = 3'd1,
		PH_WAIT    = 3'd2,
		PH_DELAY   = 3'd3,
		PH_CLOSING = 3'd4
	} phase_t;

	// Servo motion events
	typedef enum logic [1:0] {
		MOT_NONE   = 2'd0,
		MOT_OPENED = 2'd1,
		MOT_CLOSED = 2'd2
	} motion_t;

	// Control events
	typedef enum logic [1:0] {
		CTL_NONE  = 2'd0,
		CTL_OPEN  = 2'd1,
		CTL_CAR   = 2'd2
	} control_t;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_STEP_TICKS  = 3'd0,
		REG_SAFE_DELAY  = 3'd1,
		REG_OPEN_ANGLE  = 3'd2,
		REG_CLOSE_ANGLE = 3'd3,
		REG_ACTIVE_LOW  = 3'd4
	} reg_idx_t;

	localparam int unsigned PHASE_TIMER_WIDTH = 16;
	localparam int unsigned ADDR_WIDTH        = 5;
	localparam int unsigned DATA_WIDTH        = 32;

	localparam logic [9:0]  MOVE_TIMER_MAX     = 10'd1023;
	localparam logic [9:0]  RST_STEP_TICKS     = 10'd15;
	localparam logic [15:0] RST_SAFE_DELAY     = 16'd1000;
	localparam logic [7:0]  RST_OPEN_ANGLE     = 8'd90;
	localparam logic [7:0]  RST_CLOSE_ANGLE    = 8'd0;
	localparam logic        RST_ACTIVE_LOW     = 1'b1;

endpackage

FILE: rtl/barrier_gate_controller_core.sv
// Barrier gate controller top level: tick input register, single-pass state
// update and result register, APB register file. Depends on bgc_pkg.

// One input transfer is one millisecond tick and yields exactly one result
// transfer. A tick is taken every clock cycle unless the output stalls: the
// tick is captured in an input register, the whole barrier state (phase,
// servo angle, move and phase timers, car-seen and open-pending flags) is
// updated by one short combinational pass, and the result lands in an output
// register. The output register lets the next tick be processed while a
// result is being taken. Configuration registers are to be written through
// the APB port while the gate has no tick in flight; the block does not
// enforce it. A new closed angle moves the servo in idle and closing phases.
// The phase timer saturates at 2**PHASE_TIMER_WIDTH-1, the move timer at 1023.
module barrier_gate_controller_core #(
	parameter int unsigned PHASE_TIMER_WIDTH = bgc_pkg::PHASE_TIMER_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [bgc_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [bgc_pkg::DATA_WIDTH-1:0] pwdata,
	output logic [bgc_pkg::DATA_WIDTH-1:0] prdata,
	output logic        pready,
	// tick input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        open_request,
	input  logic        gate_sensor,
	input  logic [3:0]  queue_sensors,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  servo_angle,
	output logic [2:0]  gate_phase,
	output logic [1:0]  motion_event,
	output logic [1:0]  control_event,
	output logic [2:0]  waiting_count
);

	localparam int unsigned PTW   = PHASE_TIMER_WIDTH;
	localparam int unsigned CMP_W = (PTW > 16) ? PTW : 16;

	// configuration registers
	logic [9:0]  step_ticks_q;
	logic [15:0] safe_delay_q;
	logic [7:0]  open_angle_q;
	logic [7:0]  close_angle_q;
	logic        active_low_q;

	// state
	bgc_pkg::phase_t phase_q;
	logic [7:0]      angle_q;
	logic [9:0]      move_timer_q;
	logic [PTW-1:0]  phase_timer_q;
	logic            car_seen_q;
	logic            pending_q;

	// input stage
	logic        valid_s1;
	logic        req_s1;
	logic        gate_s1;
	logic [3:0]  queue_s1;

	// result register
	logic        out_valid_q;
	logic [7:0]  angle_out_q;
	logic [2:0]  phase_out_q;
	logic [1:0]  motion_out_q;
	logic [1:0]  control_out_q;
	logic [2:0]  count_out_q;

	logic advance;
	logic cfg_wr;
	bgc_pkg::reg_idx_t cfg_idx;

	// next-state values
	bgc_pkg::phase_t    phase_n;
	bgc_pkg::phase_t    phase_mid;
	logic [7:0]         angle_n;
	logic [9:0]         move_timer_n;
	logic [PTW-1:0]     phase_timer_inc;
	logic [PTW-1:0]     phase_timer_n;
	logic               car_seen_n;
	logic               pending_n;
	bgc_pkg::motion_t   motion_n;
	bgc_pkg::control_t  control_n;
	logic [2:0]         count_n;
	logic [7:0]         target;
	logic               step;
	logic               reach_open;
	logic               reach_closed;
	logic               start_open;
	logic               car_arrive;
	logic               car_leave;
	logic               delay_done;
	logic               car_gate;
	logic [3:0]         car_queue;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	// APB access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = bgc_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			bgc_pkg::REG_STEP_TICKS:  prdata = {22'd0, step_ticks_q};
			bgc_pkg::REG_SAFE_DELAY:  prdata = {16'd0, safe_delay_q};
			bgc_pkg::REG_OPEN_ANGLE:  prdata = {24'd0, open_angle_q};
			bgc_pkg::REG_CLOSE_ANGLE: prdata = {24'd0, close_angle_q};
			bgc_pkg::REG_ACTIVE_LOW:  prdata = {31'd0, active_low_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q  <= bgc_pkg::RST_STEP_TICKS;
			safe_delay_q  <= bgc_pkg::RST_SAFE_DELAY;
			open_angle_q  <= bgc_pkg::RST_OPEN_ANGLE;
			close_angle_q <= bgc_pkg::RST_CLOSE_ANGLE;
			active_low_q  <= bgc_pkg::RST_ACTIVE_LOW;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bgc_pkg::REG_STEP_TICKS:  step_ticks_q  <= pwdata[9:0];
				bgc_pkg::REG_SAFE_DELAY:  safe_delay_q  <= pwdata[15:0];
				bgc_pkg::REG_OPEN_ANGLE:  open_angle_q  <= pwdata[7:0];
				bgc_pkg::REG_CLOSE_ANGLE: close_angle_q <= pwdata[7:0];
				bgc_pkg::REG_ACTIVE_LOW:  active_low_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// capture the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1   <= open_request;
			gate_s1  <= gate_sensor;
			queue_s1 <= queue_sensors;
		end
	end

	// sensor decode: a car is present when the level differs from the polarity bit
	assign car_gate  = gate_s1 ^ active_low_q;
	assign car_queue = queue_s1 ^ {4{active_low_q}};

	always_comb begin
		count_n = 3'(car_queue[0]) + 3'(car_queue[1]) + 3'(car_queue[2]) + 3'(car_queue[3]);
	end

	// servo target for the current phase
	always_comb begin
		unique case (phase_q) inside
			bgc_pkg::PH_OPENING, bgc_pkg::PH_WAIT, bgc_pkg::PH_DELAY: target = open_angle_q;
			default: target = close_angle_q;
		endcase
	end

	// servo move and end-of-travel check
	always_comb begin
		move_timer_n    = (move_timer_q != bgc_pkg::MOVE_TIMER_MAX) ? move_timer_q + 10'd1
		                                                            : move_timer_q;
		phase_timer_inc = (phase_timer_q != {PTW{1'b1}}) ? phase_timer_q + PTW'(1)
		                                                : phase_timer_q;
		step            = (move_timer_n >= step_ticks_q);
		angle_n         = angle_q;
		if (step) begin
			move_timer_n = '0;
			if (angle_q < target) begin
				angle_n = angle_q + 8'd1;
			end else if (angle_q > target) begin
				angle_n = angle_q - 8'd1;
			end
		end
		reach_open   = step && phase_q == bgc_pkg::PH_OPENING && angle_n == open_angle_q;
		reach_closed = step && phase_q == bgc_pkg::PH_CLOSING && angle_n == close_angle_q;
		phase_mid    = phase_q;
		if (reach_open) begin
			phase_mid = bgc_pkg::PH_WAIT;
		end else if (reach_closed) begin
			phase_mid = bgc_pkg::PH_IDLE;
		end
	end

	// phase actions after the servo update
	assign start_open = (phase_mid == bgc_pkg::PH_IDLE) && (pending_q || req_s1);
	assign car_arrive = (phase_mid == bgc_pkg::PH_WAIT) && !car_seen_q && car_gate;
	assign car_leave  = (phase_mid == bgc_pkg::PH_WAIT) && car_seen_q && !car_gate;
	assign delay_done = (phase_mid == bgc_pkg::PH_DELAY) &&
	                    (CMP_W'(phase_timer_inc) >= CMP_W'(safe_delay_q));

	// next phase and flags for one tick
	always_comb begin
		phase_n       = phase_mid;
		phase_timer_n = (reach_open || reach_closed) ? '0 : phase_timer_inc;
		pending_n     = pending_q || req_s1;
		car_seen_n    = car_seen_q;
		unique case (phase_mid)
			bgc_pkg::PH_IDLE: begin
				if (start_open) begin
					pending_n     = 1'b0;
					phase_n       = bgc_pkg::PH_OPENING;
					phase_timer_n = '0;
				end
			end
			bgc_pkg::PH_WAIT: begin
				if (car_arrive) begin
					car_seen_n = 1'b1;
				end else if (car_leave) begin
					car_seen_n    = 1'b0;
					phase_n       = bgc_pkg::PH_DELAY;
					phase_timer_n = '0;
				end
			end
			bgc_pkg::PH_DELAY: begin
				if (delay_done) begin
					phase_n       = bgc_pkg::PH_CLOSING;
					phase_timer_n = '0;
				end
			end
			default: ;
		endcase
	end

	// events reported for one tick
	always_comb begin
		motion_n  = bgc_pkg::MOT_NONE;
		control_n = bgc_pkg::CTL_NONE;
		if (reach_open) begin
			motion_n = bgc_pkg::MOT_OPENED;
		end else if (reach_closed) begin
			motion_n = bgc_pkg::MOT_CLOSED;
		end
		if (start_open) begin
			control_n = bgc_pkg::CTL_OPEN;
		end else if (car_arrive) begin
			control_n = bgc_pkg::CTL_CAR;
		end
	end

	// commit state on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= bgc_pkg::PH_IDLE;
			angle_q       <= bgc_pkg::RST_CLOSE_ANGLE;
			move_timer_q  <= '0;
			phase_timer_q <= '0;
			car_seen_q    <= 1'b0;
			pending_q     <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_n;
			angle_q       <= angle_n;
			move_timer_q  <= move_timer_n;
			phase_timer_q <= phase_timer_n;
			car_seen_q    <= car_seen_n;
			pending_q     <= pending_n;
		end
	end

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			angle_out_q   <= angle_n;
			phase_out_q   <= phase_n;
			motion_out_q  <= motion_n;
			control_out_q <= control_n;
			count_out_q   <= count_n;
		end
	end

	assign servo_angle   = angle_out_q;
	assign gate_phase    = phase_out_q;
	assign motion_event  = motion_out_q;
	assign control_event = control_out_q;
	assign waiting_count = count_out_q;

`ifndef ASSERT_OFF
	// fully opened always lands in wait-for-car
	a_opened_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motion_event == bgc_pkg::MOT_OPENED |-> gate_phase == bgc_pkg::PH_WAIT)
		else $error("opened event without wait phase");

	// an opening start always reports the opening phase
	a_open_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && control_event == bgc_pkg::CTL_OPEN |-> gate_phase == bgc_pkg::PH_OPENING)
		else $error("open start without opening phase");

	// fully closed ends in idle or an immediate reopen
	a_closed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motion_event == bgc_pkg::MOT_CLOSED |->
		gate_phase == bgc_pkg::PH_IDLE || gate_phase == bgc_pkg::PH_OPENING)
		else $error("closed event in wrong phase");

	// the car flag lives only in wait-for-car
	a_car_seen: assert property (@(posedge clk) disable iff (!arst_n)
		car_seen_q |-> phase_q == bgc_pkg::PH_WAIT)
		else $error("car flag outside wait phase");

	// state holds when no tick is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(angle_q) && $stable(phase_q))
		else $error("state changed without a tick");
`endif

endmodule
